FILE: hw/rtl/rrsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrsp_pkg;

   // Default widths of the configuration registers.
   localparam int unsigned COUNT_WIDTH_DEFAULT  = 16;
   localparam int unsigned LENGTH_WIDTH_DEFAULT = 32;

   // Reset values of the configuration registers.
   localparam longint unsigned MAX_ELEMENTS_RESET    = 1024;
   localparam longint unsigned MAX_BULK_LENGTH_RESET = 64 * 1024 * 1024;

   // Result queue geometry.
   localparam int unsigned QUEUE_DEPTH     = 4;
   localparam int unsigned QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Result item kinds.
   localparam logic [1:0] ITEM_ARG_BYTE = 2'd0;
   localparam logic [1:0] ITEM_END_ARG  = 2'd1;
   localparam logic [1:0] ITEM_END_CMD  = 2'd2;
   localparam logic [1:0] ITEM_ERROR    = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_EMPTY_LENGTH = 3'd0;
   localparam logic [2:0] ERR_BARE_MINUS   = 3'd1;
   localparam logic [2:0] ERR_NON_DIGIT    = 3'd2;
   localparam logic [2:0] ERR_COUNT_RANGE  = 3'd3;
   localparam logic [2:0] ERR_NO_DOLLAR    = 3'd4;
   localparam logic [2:0] ERR_LENGTH_RANGE = 3'd5;
   localparam logic [2:0] ERR_MISSING_CRLF = 3'd6;

   // Filler for fields that carry nothing in a given item kind.
   localparam logic [2:0] NO_CODE = 3'd0;
   localparam logic [7:0] NO_BYTE = 8'd0;

   typedef struct packed {
      logic [1:0] item_type;
      logic [7:0] arg_byte;
      logic [2:0] error_code;
   } rrsp_result_type;

   // Up to two results produced by one request byte.
   typedef struct packed {
      logic [1:0]      count;
      rrsp_result_type first;
      rrsp_result_type second;
   } rrsp_push_type;

   // Appends one result to a push bundle.
   function automatic rrsp_push_type add_result(rrsp_push_type p, logic [1:0] kind,
                                                logic [7:0] data, logic [2:0] code);
      rrsp_push_type   q;
      rrsp_result_type r;
      q            = p;
      r.item_type  = kind;
      r.arg_byte   = data;
      r.error_code = code;
      if (p.count == 2'd0) begin
         q.first = r;
      end else begin
         q.second = r;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/resp_request_stream_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake            Payload
// req        in         req_valid/req_stall  req_in_byte (one request byte)
// rsp        out        rsp_valid/rsp_stall  rsp_item_type, rsp_arg_byte, rsp_error_code
// csr        in/out     APB-style, no wait   max_elements (0), max_bulk_length (1)
//
// One request byte is taken per cycle; its results enter a four-entry result queue
// and are on rsp from the next cycle, leaving at one per cycle unless rsp_stall is
// high. A byte gives up to two results, so req_stall is raised while fewer than two
// entries are free and during reset; with rsp never stalled and one result per byte
// it never rises. Reset is synchronous and returns the parser to idle with the
// registers at their defaults; after a parse error the block drops input until reset.

module resp_request_stream_parser_core #(
   parameter int unsigned COUNT_WIDTH  = rrsp_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned LENGTH_WIDTH = rrsp_pkg::LENGTH_WIDTH_DEFAULT,
   localparam int unsigned CSR_DATA_WIDTH = (LENGTH_WIDTH > 32 || COUNT_WIDTH > 32) ? 64 : 32,
   localparam int unsigned CSR_ALIGN      = (CSR_DATA_WIDTH == 64) ? 3 : 2,
   localparam int unsigned CSR_ADDR_WIDTH = CSR_ALIGN + 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,

   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_in_byte,

   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_item_type,
   output logic [7:0]                     rsp_arg_byte,
   output logic [2:0]                     rsp_error_code,

   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]      csr_prdata,
   output logic                           csr_pready
);

   logic [COUNT_WIDTH-1:0]    max_elements_ff,    max_elements_in;
   logic [LENGTH_WIDTH-1:0]   max_bulk_length_ff, max_bulk_length_in;
   logic                      csr_write;
   logic                      csr_index;
   logic                      fire;
   logic                      room;
   rrsp_pkg::rrsp_push_type   push;
   rrsp_pkg::rrsp_result_type head;

   // Register file. Low address bits select a byte lane and are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ALIGN];

   always_comb begin
      max_elements_in    = max_elements_ff;
      max_bulk_length_in = max_bulk_length_ff;
      if (csr_write) begin
         if (csr_index) begin
            max_bulk_length_in = csr_pwdata[LENGTH_WIDTH-1:0];
         end else begin
            max_elements_in = csr_pwdata[COUNT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_elements_ff    <= COUNT_WIDTH'(rrsp_pkg::MAX_ELEMENTS_RESET);
         max_bulk_length_ff <= LENGTH_WIDTH'(rrsp_pkg::MAX_BULK_LENGTH_RESET);
      end else begin
         max_elements_ff    <= max_elements_in;
         max_bulk_length_ff <= max_bulk_length_in;
      end
   end

   assign csr_prdata = csr_index ? CSR_DATA_WIDTH'(max_bulk_length_ff)
                                 : CSR_DATA_WIDTH'(max_elements_ff);

   // The input is taken whenever the result queue can absorb a full byte's worth.
   // Nothing is taken while reset is held.
   assign req_stall = reset || !room;
   assign fire      = req_valid && !req_stall;

   rrsp_parser #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .in_byte         (req_in_byte),
      .max_elements    (max_elements_ff),
      .max_bulk_length (max_bulk_length_ff),
      .push            (push)
   );

   rrsp_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (head)
   );

   assign rsp_item_type  = head.item_type;
   assign rsp_arg_byte   = head.arg_byte;
   assign rsp_error_code = head.error_code;

endmodule

`default_nettype wire

FILE: hw/rtl/rrsp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module rrsp_parser #(
   parameter int unsigned COUNT_WIDTH  = rrsp_pkg::COUNT_WIDTH_DEFAULT,
   parameter int unsigned LENGTH_WIDTH = rrsp_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire logic [7:0]              in_byte,
   input  wire logic [COUNT_WIDTH-1:0]  max_elements,
   input  wire logic [LENGTH_WIDTH-1:0] max_bulk_length,
   output rrsp_pkg::rrsp_push_type      push
);

   localparam int unsigned ACC_WIDTH  = LENGTH_WIDTH + 1;
   localparam int unsigned PROD_WIDTH = LENGTH_WIDTH + 5;
   localparam int unsigned CMP_WIDTH  = (COUNT_WIDTH > ACC_WIDTH) ? COUNT_WIDTH : ACC_WIDTH;

   localparam logic [3:0] MODE_IDLE    = 4'd0;
   localparam logic [3:0] MODE_COUNT   = 4'd1;
   localparam logic [3:0] MODE_DOLLAR  = 4'd2;
   localparam logic [3:0] MODE_LENGTH  = 4'd3;
   localparam logic [3:0] MODE_PAYLOAD = 4'd4;
   localparam logic [3:0] MODE_PAY_CR  = 4'd5;
   localparam logic [3:0] MODE_PAY_LF  = 4'd6;
   localparam logic [3:0] MODE_INLINE  = 4'd7;
   localparam logic [3:0] MODE_DEAD    = 4'd8;

   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   logic [3:0]              mode_ff,      mode_in;
   logic [ACC_WIDTH-1:0]    accum_ff,     accum_in;
   logic                    negative_ff,  negative_in;
   logic                    has_digit_ff, has_digit_in;
   logic [COUNT_WIDTH-1:0]  elems_ff,     elems_in;
   logic [LENGTH_WIDTH-1:0] payload_ff,   payload_in;
   logic                    held_cr_ff,   held_cr_in;
   logic                    word_open_ff, word_open_in;
   logic                    has_word_ff,  has_word_in;

   // Number line step, shared by the count and length lines.
   logic                    num_done;
   logic                    num_error;
   logic [2:0]              num_code;
   logic [ACC_WIDTH-1:0]    num_accum;
   logic                    num_negative;
   logic                    num_has_digit;
   logic                    num_held_cr;
   logic [PROD_WIDTH-1:0]   times_ten;
   logic                    is_digit;
   logic                    count_fits;
   logic                    length_fits;
   logic [COUNT_WIDTH-1:0]  elems_dec;
   logic [LENGTH_WIDTH-1:0] payload_dec;
   rrsp_pkg::rrsp_push_type push_v;

   assign is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign times_ten = (PROD_WIDTH'(accum_ff) << 3) + (PROD_WIDTH'(accum_ff) << 1)
                    + PROD_WIDTH'(in_byte[3:0]);

   always_comb begin
      num_done      = 1'b0;
      num_error     = 1'b0;
      num_code      = rrsp_pkg::ERR_NON_DIGIT;
      num_accum     = accum_ff;
      num_negative  = negative_ff;
      num_has_digit = has_digit_ff;
      num_held_cr   = held_cr_ff;
      if (held_cr_ff) begin
         num_held_cr = 1'b0;
         if (in_byte != CHAR_LF) begin
            num_error = 1'b1;
         end else if (!has_digit_ff) begin
            num_error = 1'b1;
            num_code  = negative_ff ? rrsp_pkg::ERR_BARE_MINUS : rrsp_pkg::ERR_EMPTY_LENGTH;
         end else begin
            num_done = 1'b1;
         end
      end else if (in_byte == CHAR_CR) begin
         num_held_cr = 1'b1;
      end else if (in_byte == CHAR_MINUS && !negative_ff && !has_digit_ff) begin
         num_negative = 1'b1;
      end else if (is_digit) begin
         // Saturate at all ones; such a value is above every limit.
         if (|times_ten[PROD_WIDTH-1:ACC_WIDTH]) begin
            num_accum = '1;
         end else begin
            num_accum = times_ten[ACC_WIDTH-1:0];
         end
         num_has_digit = 1'b1;
      end else begin
         num_error = 1'b1;
      end
   end

   // Minus zero is zero; any other negative value is out of range.
   assign count_fits  = !(negative_ff && accum_ff != '0)
                      && (CMP_WIDTH'(accum_ff) <= CMP_WIDTH'(max_elements));
   assign length_fits = !(negative_ff && accum_ff != '0)
                      && (accum_ff <= ACC_WIDTH'(max_bulk_length));
   assign elems_dec   = elems_ff - COUNT_WIDTH'(1);
   assign payload_dec = payload_ff - LENGTH_WIDTH'(1);

   always_comb begin
      mode_in      = mode_ff;
      accum_in     = accum_ff;
      negative_in  = negative_ff;
      has_digit_in = has_digit_ff;
      elems_in     = elems_ff;
      payload_in   = payload_ff;
      held_cr_in   = held_cr_ff;
      word_open_in = word_open_ff;
      has_word_in  = has_word_ff;
      push_v       = '0;

      case (mode_ff)
         MODE_IDLE: begin
            accum_in     = '0;
            negative_in  = 1'b0;
            has_digit_in = 1'b0;
            held_cr_in   = 1'b0;
            word_open_in = 1'b0;
            has_word_in  = 1'b0;
            if (in_byte == CHAR_STAR) begin
               mode_in = MODE_COUNT;
            end else begin
               mode_in = MODE_INLINE;
               if (in_byte == CHAR_CR) begin
                  held_cr_in = 1'b1;
               end else if (in_byte != CHAR_SPACE) begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ARG_BYTE, in_byte,
                                                rrsp_pkg::NO_CODE);
                  word_open_in = 1'b1;
                  has_word_in  = 1'b1;
               end
            end
         end
         MODE_INLINE: begin
            if (held_cr_ff && in_byte == CHAR_LF) begin
               held_cr_in = 1'b0;
               if (word_open_ff) begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_END_ARG,
                                                rrsp_pkg::NO_BYTE, rrsp_pkg::NO_CODE);
               end
               if (has_word_ff) begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_END_CMD,
                                                rrsp_pkg::NO_BYTE, rrsp_pkg::NO_CODE);
               end
               word_open_in = 1'b0;
               has_word_in  = 1'b0;
               mode_in      = MODE_IDLE;
            end else begin
               // A held CR without LF is an ordinary word byte.
               if (held_cr_ff) begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ARG_BYTE, CHAR_CR,
                                                rrsp_pkg::NO_CODE);
               end
               held_cr_in = 1'b0;
               if (in_byte == CHAR_CR) begin
                  held_cr_in   = 1'b1;
                  word_open_in = word_open_ff || held_cr_ff;
                  has_word_in  = has_word_ff || held_cr_ff;
               end else if (in_byte == CHAR_SPACE) begin
                  if (word_open_ff || held_cr_ff) begin
                     push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_END_ARG,
                                                   rrsp_pkg::NO_BYTE, rrsp_pkg::NO_CODE);
                  end
                  word_open_in = 1'b0;
                  has_word_in  = has_word_ff || held_cr_ff;
               end else begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ARG_BYTE, in_byte,
                                                rrsp_pkg::NO_CODE);
                  word_open_in = 1'b1;
                  has_word_in  = 1'b1;
               end
            end
         end
         MODE_COUNT: begin
            accum_in     = num_accum;
            negative_in  = num_negative;
            has_digit_in = num_has_digit;
            held_cr_in   = num_held_cr;
            if (num_error) begin
               push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ERROR,
                                             rrsp_pkg::NO_BYTE, num_code);
               mode_in = MODE_DEAD;
            end else if (num_done) begin
               if (!count_fits) begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ERROR,
                                                rrsp_pkg::NO_BYTE, rrsp_pkg::ERR_COUNT_RANGE);
                  mode_in = MODE_DEAD;
               end else begin
                  elems_in = COUNT_WIDTH'(accum_ff);
                  mode_in  = (COUNT_WIDTH'(accum_ff) == '0) ? MODE_IDLE : MODE_DOLLAR;
               end
            end
         end
         MODE_DOLLAR: begin
            if (in_byte != CHAR_DOLLAR) begin
               push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ERROR,
                                             rrsp_pkg::NO_BYTE, rrsp_pkg::ERR_NO_DOLLAR);
               mode_in = MODE_DEAD;
            end else begin
               accum_in     = '0;
               negative_in  = 1'b0;
               has_digit_in = 1'b0;
               held_cr_in   = 1'b0;
               mode_in      = MODE_LENGTH;
            end
         end
         MODE_LENGTH: begin
            accum_in     = num_accum;
            negative_in  = num_negative;
            has_digit_in = num_has_digit;
            held_cr_in   = num_held_cr;
            if (num_error) begin
               push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ERROR,
                                             rrsp_pkg::NO_BYTE, num_code);
               mode_in = MODE_DEAD;
            end else if (num_done) begin
               if (!length_fits) begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ERROR,
                                                rrsp_pkg::NO_BYTE, rrsp_pkg::ERR_LENGTH_RANGE);
                  mode_in = MODE_DEAD;
               end else begin
                  payload_in = accum_ff[LENGTH_WIDTH-1:0];
                  mode_in    = (accum_ff[LENGTH_WIDTH-1:0] == '0) ? MODE_PAY_CR : MODE_PAYLOAD;
               end
            end
         end
         MODE_PAYLOAD: begin
            push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ARG_BYTE, in_byte,
                                          rrsp_pkg::NO_CODE);
            payload_in = payload_dec;
            if (payload_dec == '0) begin
               mode_in = MODE_PAY_CR;
            end
         end
         MODE_PAY_CR: begin
            if (in_byte != CHAR_CR) begin
               push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ERROR,
                                             rrsp_pkg::NO_BYTE, rrsp_pkg::ERR_MISSING_CRLF);
               mode_in = MODE_DEAD;
            end else begin
               mode_in = MODE_PAY_LF;
            end
         end
         MODE_PAY_LF: begin
            if (in_byte != CHAR_LF) begin
               push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_ERROR,
                                             rrsp_pkg::NO_BYTE, rrsp_pkg::ERR_MISSING_CRLF);
               mode_in = MODE_DEAD;
            end else begin
               push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_END_ARG,
                                             rrsp_pkg::NO_BYTE, rrsp_pkg::NO_CODE);
               elems_in = elems_dec;
               if (elems_dec == '0) begin
                  push_v = rrsp_pkg::add_result(push_v, rrsp_pkg::ITEM_END_CMD,
                                                rrsp_pkg::NO_BYTE, rrsp_pkg::NO_CODE);
                  mode_in = MODE_IDLE;
               end else begin
                  mode_in = MODE_DOLLAR;
               end
            end
         end
         default: begin
            // After an error every byte is dropped until reset.
            mode_in = MODE_DEAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         accum_ff     <= '0;
         negative_ff  <= 1'b0;
         has_digit_ff <= 1'b0;
         elems_ff     <= '0;
         payload_ff   <= '0;
         held_cr_ff   <= 1'b0;
         word_open_ff <= 1'b0;
         has_word_ff  <= 1'b0;
      end else if (fire) begin
         mode_ff      <= mode_in;
         accum_ff     <= accum_in;
         negative_ff  <= negative_in;
         has_digit_ff <= has_digit_in;
         elems_ff     <= elems_in;
         payload_ff   <= payload_in;
         held_cr_ff   <= held_cr_in;
         word_open_ff <= word_open_in;
         has_word_ff  <= has_word_in;
      end
   end

   always_comb begin
      push       = push_v;
      push.count = fire ? push_v.count : 2'd0;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rrsp_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rrsp_result_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rrsp_pkg::rrsp_push_type push,
   output logic                         room,
   output logic                         out_valid,
   input  wire logic                    out_stall,
   output rrsp_pkg::rrsp_result_type    out_result
);

   localparam int unsigned PTR_W = rrsp_pkg::QUEUE_PTR_WIDTH;
   localparam int unsigned CNT_W = rrsp_pkg::QUEUE_CNT_WIDTH;

   rrsp_pkg::rrsp_result_type entry_ff [rrsp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [PTR_W-1:0] wr_next;
   logic             pop;

   assign pop        = out_valid && !out_stall;
   assign out_valid  = count_ff != '0;
   assign out_result = entry_ff[rd_ptr_ff];
   // A byte may produce two results, so two free entries are needed to take it.
   assign room       = count_ff <= CNT_W'(rrsp_pkg::QUEUE_DEPTH - 2);

   assign wr_next   = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the streaming request parser.
//
// Request bytes go in one at a time on the req channel. A scoreboard process
// on the rising edge does three things in a fixed order: it checks any result
// leaving on rsp against the oldest expected result, it tracks register writes
// and checks register reads, and it runs the accepted request byte through a
// local parser model that queues the results that byte should produce. Doing
// all of that in one process keeps the outcome independent of the order in
// which processes wake up within a time step.
//
// A parse error leaves the block silent until reset, and reset is applied only
// once. The clean traffic therefore runs first, and a single broken request,
// picked at random, ends the run.

module tb_top;

   localparam int COUNT_W = rrsp_pkg::COUNT_WIDTH_DEFAULT;
   localparam int LENGTH_W = rrsp_pkg::LENGTH_WIDTH_DEFAULT;
   localparam longint unsigned ACCUM_CEILING = (64'd1 << (LENGTH_W + 1)) - 1;

   // Register indexes. Each register sits at byte address 4 * index.
   localparam int REG_MAX_ELEMENTS = 0;
   localparam int REG_MAX_BULK_LENGTH = 1;

   // Protocol characters.
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   // Outcomes of feeding one byte to a number line, beside the error codes.
   localparam int NUM_MORE = -1;
   localparam int NUM_DONE = -2;

   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES = 120;

   typedef enum logic [3:0] {
      PM_IDLE,
      PM_COUNT,
      PM_DOLLAR,
      PM_LENGTH,
      PM_PAYLOAD,
      PM_PAY_CR,
      PM_PAY_LF,
      PM_INLINE,
      PM_DEAD
   } parse_mode_type;

   // The malformed requests that can close the run.
   typedef enum int {
      BAD_EMPTY_COUNT,
      BAD_BARE_MINUS,
      BAD_COUNT_LETTER,
      BAD_COUNT_LONE_CR,
      BAD_COUNT_ABOVE_LIMIT,
      BAD_COUNT_NEGATIVE,
      BAD_COUNT_OVERFLOW,
      BAD_NO_DOLLAR,
      BAD_LENGTH_ABOVE_LIMIT,
      BAD_EMPTY_LENGTH,
      BAD_PAYLOAD_END,
      BAD_KIND_COUNT
   } broken_kind_type;

   logic clock = 1'b0;
   logic reset;

   logic req_valid;
   logic req_stall;
   logic [7:0] req_in_byte;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_item_type;
   logic [7:0] rsp_arg_byte;
   logic [2:0] rsp_error_code;

   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Register values as the block should hold them.
   logic [COUNT_W-1:0] cfg_max_elements = COUNT_W'(rrsp_pkg::MAX_ELEMENTS_RESET);
   logic [LENGTH_W-1:0] cfg_max_bulk = LENGTH_W'(rrsp_pkg::MAX_BULK_LENGTH_RESET);

   // Parser state of the local model.
   parse_mode_type pm_mode = PM_IDLE;
   logic [LENGTH_W:0] pm_accum = '0;
   logic pm_negative = 1'b0;
   logic pm_has_digit = 1'b0;
   logic [COUNT_W-1:0] pm_elems_left = '0;
   logic [LENGTH_W-1:0] pm_pay_left = '0;
   logic pm_held_cr = 1'b0;
   logic pm_word_open = 1'b0;
   logic pm_cmd_has_word = 1'b0;

   rrsp_pkg::rrsp_result_type expected_items[$];

   int error_count = 0;
   int bytes_sent = 0;
   int idle_cycles = 0;

   // Traffic shaping. steady turns off the random gaps on both sides; a hold
   // request makes the receiver stall for a long stretch.
   bit steady = 1'b0;
   int holds_requested = 0;
   int holds_served = 0;
   int stall_left = 0;
   int rsp_gap;

   resp_request_stream_parser_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item_type  (rsp_item_type),
      .rsp_arg_byte   (rsp_arg_byte),
      .rsp_error_code (rsp_error_code),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap lengths: mostly none, often a few cycles, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady) begin
         return 0;
      end
      if (roll < 60) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      if (roll < 98) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Parser model
   // ------------------------------------------------------------------------

   function automatic void expect_result(logic [1:0] kind, logic [7:0] data, logic [2:0] code);
      rrsp_pkg::rrsp_result_type r;
      r.item_type = kind;
      r.arg_byte = data;
      r.error_code = code;
      expected_items.insert(expected_items.size(), r);
   endfunction

   // An error emits one error item and then the parser ignores everything.
   function automatic void parse_fail(logic [2:0] code);
      expect_result(rrsp_pkg::ITEM_ERROR, rrsp_pkg::NO_BYTE, code);
      pm_mode = PM_DEAD;
   endfunction

   function automatic void clear_number();
      pm_accum = '0;
      pm_negative = 1'b0;
      pm_has_digit = 1'b0;
      pm_held_cr = 1'b0;
   endfunction

   // One byte of a count or length line. The accumulator saturates, so any
   // overlong number still ends up above every register limit.
   function automatic int number_step(logic [7:0] b);
      longint unsigned wide;
      if (pm_held_cr) begin
         pm_held_cr = 1'b0;
         if (b != CH_LF) begin
            return int'(rrsp_pkg::ERR_NON_DIGIT);
         end
         if (!pm_has_digit) begin
            return pm_negative ? int'(rrsp_pkg::ERR_BARE_MINUS)
                               : int'(rrsp_pkg::ERR_EMPTY_LENGTH);
         end
         return NUM_DONE;
      end
      if (b == CH_CR) begin
         pm_held_cr = 1'b1;
         return NUM_MORE;
      end
      if (b == CH_MINUS && !pm_negative && !pm_has_digit) begin
         pm_negative = 1'b1;
         return NUM_MORE;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
         wide = longint'(pm_accum) * 10 + longint'(b - CH_ZERO);
         if (wide > ACCUM_CEILING) begin
            wide = ACCUM_CEILING;
         end
         pm_accum = wide[LENGTH_W:0];
         pm_has_digit = 1'b1;
         return NUM_MORE;
      end
      return int'(rrsp_pkg::ERR_NON_DIGIT);
   endfunction

   // Minus zero is plain zero; any other negative number is out of range.
   function automatic bit number_fits(longint unsigned limit);
      if (pm_negative && pm_accum != 0) begin
         return 1'b0;
      end
      return longint'(pm_accum) <= limit;
   endfunction

   function automatic void inline_char(logic [7:0] b);
      if (b == CH_CR) begin
         pm_held_cr = 1'b1;
      end else if (b == CH_SPACE) begin
         if (pm_word_open) begin
            expect_result(rrsp_pkg::ITEM_END_ARG, rrsp_pkg::NO_BYTE, rrsp_pkg::NO_CODE);
            pm_word_open = 1'b0;
         end
      end else begin
         expect_result(rrsp_pkg::ITEM_ARG_BYTE, b, rrsp_pkg::NO_CODE);
         pm_word_open = 1'b1;
         pm_cmd_has_word = 1'b1;
      end
   endfunction

   function automatic void predict_byte(logic [7:0] b);
      int outcome;
      case (pm_mode)
         PM_IDLE: begin
            clear_number();
            pm_word_open = 1'b0;
            pm_cmd_has_word = 1'b0;
            if (b == CH_STAR) begin
               pm_mode = PM_COUNT;
            end else begin
               pm_mode = PM_INLINE;
               inline_char(b);
            end
         end
         PM_INLINE: begin
            if (pm_held_cr && b == CH_LF) begin
               // End of line. A line without words produces nothing at all.
               pm_held_cr = 1'b0;
               if (pm_word_open) begin
                  expect_result(rrsp_pkg::ITEM_END_ARG, rrsp_pkg::NO_BYTE,
                                rrsp_pkg::NO_CODE);
               end
               if (pm_cmd_has_word) begin
                  expect_result(rrsp_pkg::ITEM_END_CMD, rrsp_pkg::NO_BYTE,
                                rrsp_pkg::NO_CODE);
               end
               pm_word_open = 1'b0;
               pm_cmd_has_word = 1'b0;
               pm_mode = PM_IDLE;
            end else begin
               // A held CR that is not followed by LF is an ordinary word byte,
               // and it comes out ahead of the current byte.
               if (pm_held_cr) begin
                  pm_held_cr = 1'b0;
                  expect_result(rrsp_pkg::ITEM_ARG_BYTE, CH_CR, rrsp_pkg::NO_CODE);
                  pm_word_open = 1'b1;
                  pm_cmd_has_word = 1'b1;
               end
               inline_char(b);
            end
         end
         PM_COUNT: begin
            outcome = number_step(b);
            if (outcome == NUM_DONE) begin
               if (!number_fits(longint'(cfg_max_elements))) begin
                  parse_fail(rrsp_pkg::ERR_COUNT_RANGE);
               end else begin
                  pm_elems_left = pm_accum[COUNT_W-1:0];
                  pm_mode = (pm_elems_left == 0) ? PM_IDLE : PM_DOLLAR;
               end
            end else if (outcome != NUM_MORE) begin
               parse_fail(outcome[2:0]);
            end
         end
         PM_DOLLAR: begin
            if (b != CH_DOLLAR) begin
               parse_fail(rrsp_pkg::ERR_NO_DOLLAR);
            end else begin
               clear_number();
               pm_mode = PM_LENGTH;
            end
         end
         PM_LENGTH: begin
            outcome = number_step(b);
            if (outcome == NUM_DONE) begin
               if (!number_fits(longint'(cfg_max_bulk))) begin
                  parse_fail(rrsp_pkg::ERR_LENGTH_RANGE);
               end else begin
                  pm_pay_left = pm_accum[LENGTH_W-1:0];
                  pm_mode = (pm_pay_left == 0) ? PM_PAY_CR : PM_PAYLOAD;
               end
            end else if (outcome != NUM_MORE) begin
               parse_fail(outcome[2:0]);
            end
         end
         PM_PAYLOAD: begin
            expect_result(rrsp_pkg::ITEM_ARG_BYTE, b, rrsp_pkg::NO_CODE);
            pm_pay_left = pm_pay_left - 1'b1;
            if (pm_pay_left == 0) begin
               pm_mode = PM_PAY_CR;
            end
         end
         PM_PAY_CR: begin
            if (b != CH_CR) begin
               parse_fail(rrsp_pkg::ERR_MISSING_CRLF);
            end else begin
               pm_mode = PM_PAY_LF;
            end
         end
         PM_PAY_LF: begin
            if (b != CH_LF) begin
               parse_fail(rrsp_pkg::ERR_MISSING_CRLF);
            end else begin
               expect_result(rrsp_pkg::ITEM_END_ARG, rrsp_pkg::NO_BYTE, rrsp_pkg::NO_CODE);
               pm_elems_left = pm_elems_left - 1'b1;
               if (pm_elems_left == 0) begin
                  expect_result(rrsp_pkg::ITEM_END_CMD, rrsp_pkg::NO_BYTE,
                                rrsp_pkg::NO_CODE);
                  pm_mode = PM_IDLE;
               end else begin
                  pm_mode = PM_DOLLAR;
               end
            end
         end
         default: begin
            pm_mode = PM_DEAD;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Scoreboard
   // ------------------------------------------------------------------------

   function automatic void check_field(string what, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rrsp_pkg::rrsp_result_type want;
      if (!reset) begin
         // Results leaving the block first, then register traffic, then the
         // request byte accepted at this same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_items.size() == 0) begin
               error_count++;
               $display("%0t: expected no result, got type %0d byte 0x%02h code %0d",
                        $time, rsp_item_type, rsp_arg_byte, rsp_error_code);
            end else begin
               want = expected_items.pop_front();
               check_field("item_type", want.item_type, rsp_item_type);
               check_field("arg_byte", want.arg_byte, rsp_arg_byte);
               check_field("error_code", want.error_code, rsp_error_code);
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (int'(csr_paddr >> 2))
                  REG_MAX_ELEMENTS: cfg_max_elements = csr_pwdata[COUNT_W-1:0];
                  REG_MAX_BULK_LENGTH: cfg_max_bulk = csr_pwdata[LENGTH_W-1:0];
                  default: ;
               endcase
            end else if (int'(csr_paddr >> 2) == REG_MAX_ELEMENTS) begin
               check_field("max_elements read", longint'(cfg_max_elements), csr_prdata);
            end else begin
               check_field("max_bulk_length read", longint'(cfg_max_bulk), csr_prdata);
            end
         end
         if (req_valid && !req_stall) begin
            predict_byte(req_in_byte);
         end
      end
   end

   // The run is stuck if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                     WATCHDOG_LIMIT, expected_items.size());
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold whenever the test asks.
   always @(negedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served = holds_requested;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_gap = pick_gap();
         rsp_stall <= (rsp_gap > 0);
         stall_left = (rsp_gap > 0) ? rsp_gap - 1 : 0;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Offers one byte, waits for the edge that takes it and then leaves an optional
   // idle gap. The byte holds steady for as long as the block stalls.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_in_byte = b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      bytes_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   task automatic send_crlf();
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   // A count or length line. Zero is sometimes written as minus zero, and
   // some lines carry leading zeros.
   task automatic send_number_line(input logic [7:0] lead, input longint unsigned value);
      send_byte(lead);
      if (value == 0 && $urandom_range(0, 3) == 0) begin
         send_byte(CH_MINUS);
      end
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) send_byte(CH_ZERO);
      end
      send_text($sformatf("%0d", value));
      send_crlf();
   endtask

   task automatic send_element_bytes(input logic [7:0] data[$]);
      int i;
      send_number_line(CH_DOLLAR, data.size());
      for (i = 0; i < data.size(); i++) begin
         send_byte(data[i]);
      end
      send_crlf();
   endtask

   task automatic send_element_text(input string s);
      send_number_line(CH_DOLLAR, s.len());
      send_text(s);
      send_crlf();
   endtask

   // Drops valid and waits until every expected result has left the block,
   // then a few more cycles for anything still in flight.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_items.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit write, input int index, input logic [31:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = write;
      csr_paddr = 3'(index << 2);
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Registers change only with the parser idle and nothing in flight.
   task automatic set_limits(input logic [31:0] elements, input logic [31:0] bulk);
      wait_for_results();
      csr_access(1'b1, REG_MAX_ELEMENTS, elements);
      csr_access(1'b1, REG_MAX_BULK_LENGTH, bulk);
      csr_access(1'b0, REG_MAX_ELEMENTS, '0);
      csr_access(1'b0, REG_MAX_BULK_LENGTH, '0);
   endtask

   // A well-formed multibulk command with random payloads within the limits.
   task automatic random_bulk_command();
      int count;
      int cap;
      int len;
      int i;
      int j;
      logic [7:0] data[$];
      cap = (cfg_max_elements < 6) ? int'(cfg_max_elements) : 6;
      count = $urandom_range(0, cap);
      send_number_line(CH_STAR, count);
      for (i = 0; i < count; i++) begin
         cap = ($urandom_range(0, 9) == 0) ? 40 : 8;
         if (cfg_max_bulk < cap) begin
            cap = int'(cfg_max_bulk);
         end
         len = $urandom_range(0, cap);
         data.delete();
         for (j = 0; j < len; j++) begin
            data.insert(data.size(), 8'($urandom_range(0, 255)));
         end
         send_element_bytes(data);
      end
   endtask

   // An inline line of random bytes, heavy on spaces and with stray CRs. The
   // first byte never opens a multibulk and no CR LF ends the line early.
   task automatic random_inline_line();
      int n;
      int i;
      int roll;
      logic [7:0] b;
      logic [7:0] prev;
      n = $urandom_range(0, 24);
      prev = 8'h00;
      for (i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            b = CH_SPACE;
         end else if (roll < 40) begin
            b = CH_CR;
         end else begin
            b = 8'($urandom_range(0, 255));
         end
         if (i == 0 && b == CH_STAR) begin
            b = CH_SPACE;
         end
         if (prev == CH_CR && b == CH_LF) begin
            b = "x";
         end
         send_byte(b);
         prev = b;
      end
      send_crlf();
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_bulk_basics();
      logic [7:0] extremes[$];
      extremes = '{8'h00, 8'hFF, CH_CR, CH_LF, CH_STAR, CH_DOLLAR, 8'h7F, 8'h80};
      // Two arguments, the second one empty.
      send_number_line(CH_STAR, 2);
      send_element_text("GET");
      send_element_text("");
      // Empty commands, also with minus zero as the count.
      send_text("*0");
      send_crlf();
      send_text("*-0");
      send_crlf();
      // Leading zeros in a count and a length, minus zero as a length.
      send_text("*0002");
      send_crlf();
      send_text("$-0");
      send_crlf();
      send_crlf();
      send_text("$003");
      send_crlf();
      send_text("abc");
      send_crlf();
      // Payload with the extreme byte values and protocol characters inside.
      send_number_line(CH_STAR, 1);
      send_element_bytes(extremes);
   endtask

   task automatic test_inline_lines();
      send_text("PING");
      send_crlf();
      send_text("  SET  key  val ");
      send_crlf();
      // A line with no words, and one with only spaces, produce nothing.
      send_crlf();
      send_text("   ");
      send_crlf();
      // Lone CRs are word bytes, including one right before the line end.
      send_text("a");
      send_byte(CH_CR);
      send_text("b");
      send_byte(CH_CR);
      send_crlf();
      send_text("$-9 x");
      send_crlf();
   endtask

   task automatic test_register_limits();
      // Upper bits of a narrow register are dropped: this sets a limit of 3.
      set_limits(32'hABCD_0003, 32'd4);
      send_number_line(CH_STAR, 3);
      send_element_text("abcd");
      send_element_text("");
      send_element_text("wxyz");
      // Both limits at zero still allow empty commands and inline lines.
      set_limits(32'd0, 32'd0);
      send_text("*0");
      send_crlf();
      send_text("*-0");
      send_crlf();
      send_text("QUIT now");
      send_crlf();
      // Both limits at their top values.
      set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_number_line(CH_STAR, 2);
      send_element_text("hi");
      send_element_text("there");
   endtask

   // The receiver holds off while the sender keeps offering bytes, so the
   // result queue fills and the block stalls its input. Afterwards the sender
   // waits until everything has drained.
   task automatic test_receiver_hold();
      int i;
      set_limits(32'd16, 32'd64);
      steady = 1'b1;
      holds_requested++;
      for (i = 0; i < 4; i++) begin
         random_bulk_command();
      end
      send_text("HOLD ME");
      send_crlf();
      steady = 1'b0;
      wait_for_results();
   endtask

   task automatic random_phase(input logic [31:0] elements, input logic [31:0] bulk);
      int stop_at;
      set_limits(elements, bulk);
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
         steady = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 99) < 60) begin
            random_bulk_command();
         end else begin
            random_inline_line();
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_random_traffic();
      random_phase(32'(rrsp_pkg::MAX_ELEMENTS_RESET), 32'(rrsp_pkg::MAX_BULK_LENGTH_RESET));
      random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_phase($urandom_range(1, 8), $urandom_range(1, 16));
      random_phase(32'd2, 32'd0);
   endtask

   // One malformed request, then bytes that the dead parser must ignore.
   task automatic test_parse_error();
      broken_kind_type kind;
      longint unsigned len;
      set_limits($urandom_range(1, 100), $urandom_range(0, 50));
      kind = broken_kind_type'($urandom_range(0, int'(BAD_KIND_COUNT) - 1));
      random_bulk_command();
      case (kind)
         BAD_EMPTY_COUNT: begin
            send_byte(CH_STAR);
            send_crlf();
         end
         BAD_BARE_MINUS: begin
            send_text("*-");
            send_crlf();
         end
         BAD_COUNT_LETTER: begin
            send_text("*12a");
         end
         BAD_COUNT_LONE_CR: begin
            send_text("*1");
            send_byte(CH_CR);
            send_text("x");
         end
         BAD_COUNT_ABOVE_LIMIT: begin
            send_number_line(CH_STAR, longint'(cfg_max_elements) + 1);
         end
         BAD_COUNT_NEGATIVE: begin
            send_text("*-5");
            send_crlf();
         end
         BAD_COUNT_OVERFLOW: begin
            send_text("*99999999999999999999");
            send_crlf();
         end
         BAD_NO_DOLLAR: begin
            send_number_line(CH_STAR, 1);
            send_text("#");
         end
         BAD_LENGTH_ABOVE_LIMIT: begin
            send_number_line(CH_STAR, 1);
            send_number_line(CH_DOLLAR, longint'(cfg_max_bulk) + 1);
         end
         BAD_EMPTY_LENGTH: begin
            send_number_line(CH_STAR, 1);
            send_byte(CH_DOLLAR);
            send_crlf();
         end
         default: begin
            // The payload end is wrong either at its CR or at its LF.
            len = (cfg_max_bulk > 0) ? 1 : 0;
            send_number_line(CH_STAR, 1);
            send_number_line(CH_DOLLAR, len);
            if (len != 0) begin
               send_text("a");
            end
            if ($urandom_range(0, 1) == 0) begin
               send_byte(CH_CR);
            end
            send_text("Z");
         end
      endcase
      repeat (16) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_bulk_basics();
      test_inline_lines();
      test_register_limits();
      test_receiver_hold();
      test_random_traffic();
      test_parse_error();

      wait_for_results();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: resp_request_stream_parser_core.f
hw/rtl/rrsp_pkg.sv
hw/rtl/rrsp_parser.sv
hw/rtl/rrsp_result_queue.sv
hw/rtl/resp_request_stream_parser_core.sv
verif/tb_top.sv
